>>> hdl/assert_macros.svh
// Assertion macros for the RTL; vent_ctrl is the module that includes them.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with active-low reset masking.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check without reset masking.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/vent_pkg.sv
// Package of the vertical edge block: sizes, codes, state type and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package vent_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int RING_ROWS  = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int RING_W     = $clog2(RING_ROWS);
    localparam int ADDR_W     = RING_W + COL_W;
    localparam int WID_W      = 12;
    localparam int HGT_W      = 13;
    localparam int N_W        = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUM_W      = 43;
    localparam int MAG_W      = 20;
    localparam int S_W        = 11;
    localparam int SCALE_W    = 4;
    localparam int PIX_W      = 8;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DAT_W  = 13;
    localparam int LHS_W      = MAG_W + N_W;
    localparam int RHS_W      = SUM_W + SCALE_W;

    localparam logic [REQ_W-1:0] REQ_ACC   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EMIT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd2;

    localparam logic [2:0] TAP_LAST  = 3'd5;
    localparam logic [2:0] SLOT_LAST = 3'd4;

    localparam logic [PIX_W-1:0] EDGE_ON = 8'd255;

    typedef enum logic [3:0] {
        S_IDLE, S_MLD, S_MRD, S_MACC, S_MSQ, S_MSUM, S_CMP1, S_CMP2, S_OUT
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [RING_W-1:0] wr_row;
        logic [COL_W-1:0]  wr_col;
        logic              ld_job;
        logic [ROW_W-1:0]  job_row;
        logic [COL_W-1:0]  job_col;
        logic              rd_en;
        logic [2:0]        tap;
        logic              sq_en;
        logic [2:0]        slot;
        logic              sum_add;
        logic              sum_clr;
        logic              cmp1;
        logic              cmp2;
        logic              hit_clr;
        logic              out_load;
        logic              out_last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;
endpackage

>>> hdl/vertical_edge_nms_threshold.sv
// Pass 0 pixel: stored, then up to two magnitudes summed into the frame sum.
// Pass 1: a border result goes straight to the output register; an interior
// result needs five magnitudes of six reads each on one memory port.
// Results lag input by at least 2*W+2 pixels until the frame is all in.
// Reset is synchronous, active low; the row memory is not cleared.
`timescale 1ns / 1ps
module vertical_edge_nms_threshold import vent_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] gray_pixel
    input  logic [REQ_W-1:0]     s_axis_tuser,   // [1:0] req_type
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [PIX_W-1:0]     m_axis_tdata,   // [7:0] edge_value
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);
    logic [WID_W-1:0]   r_width;
    logic [HGT_W-1:0]   r_height;
    logic [SCALE_W-1:0] r_scale;
    logic [N_W-1:0]     r_npix;
    logic [WID_W-1:0]   eff_w;
    logic [HGT_W-1:0]   eff_h;
    logic [WID_W+HGT_W-1:0] prod;
    logic               cfg_wr, geom_wr;
    t_cmd               cmd;
    t_stat              stat;

    always_comb begin
        eff_w = r_width;
        if (r_width < WID_W'(3)) begin
            eff_w = WID_W'(3);
        end else if (r_width > WID_W'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end
        eff_h = r_height;
        if (r_height < HGT_W'(3)) begin
            eff_h = HGT_W'(3);
        end else if (r_height > HGT_W'(MAX_HEIGHT)) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end
        prod    = eff_w * eff_h;
        cfg_wr  = i_cfg_valid && o_cfg_ready;
        geom_wr = cfg_wr && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(640);
            r_height <= HGT_W'(480);
            r_scale  <= SCALE_W'(4);
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[HGT_W-1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                default:    r_scale  <= r_scale;
            endcase
        end
        r_npix <= prod[N_W-1:0];
    end

    vent_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_req     (s_axis_tuser),
        .i_width   (eff_w),
        .i_height  (eff_h),
        .i_npix    (r_npix),
        .i_geom_wr (geom_wr),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    vent_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_pixel  (s_axis_tdata),
        .i_width  (eff_w),
        .i_height (eff_h),
        .i_npix   (r_npix),
        .i_scale  (r_scale),
        .o_stat   (stat),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_edge   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );
endmodule

>>> hdl/vent_dp.sv
// Datapath: gray ring memory, gradient accumulation, squaring, magnitude
// sum, threshold and suppression compare, output register. Uses vent_pkg.
`timescale 1ns / 1ps
module vent_dp import vent_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic [WID_W-1:0]   i_width,
    input  logic [HGT_W-1:0]   i_height,
    input  logic [N_W-1:0]     i_npix,
    input  logic [SCALE_W-1:0] i_scale,
    output t_stat              o_stat,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_edge,
    output logic               o_last
);
    logic [PIX_W-1:0]        r_mem [RING_ROWS*MAX_WIDTH];
    logic [PIX_W-1:0]        r_rd;
    logic [2:0]              r_rd_tap;
    logic                    r_rd_v;
    logic [RING_W-1:0]       r_up, r_mid, r_dn;
    logic [COL_W-1:0]        r_cp, r_cm;
    logic                    r_zero;
    logic signed [S_W-1:0]   r_s;
    logic [MAG_W-1:0]        r_slot [5];
    logic [MAG_W-1:0]        r_mq;
    logic [SUM_W-1:0]        r_sum;
    logic [LHS_W-1:0]        r_lhs;
    logic [RHS_W-1:0]        r_rhs;
    logic                    r_hit;
    logic                    r_ov;
    logic [PIX_W-1:0]        r_oedge;
    logic                    r_olast;

    logic [ADDR_W-1:0]       rd_addr;
    logic [RING_W-1:0]       rd_row;
    logic signed [S_W-1:0]   term;
    logic signed [2*S_W-1:0] sq;
    logic [MAG_W-1:0]        mag;
    logic                    nms;

    always_comb begin
        case (i_cmd.tap[2:1])
            2'd0:    rd_row = r_up;
            2'd1:    rd_row = r_mid;
            default: rd_row = r_dn;
        endcase
        rd_addr = {rd_row, (i_cmd.tap[0] ? r_cm : r_cp)};
        if (r_rd_tap[2:1] == 2'd1) begin
            term = $signed({2'b00, r_rd, 1'b0});
        end else begin
            term = $signed({3'b000, r_rd});
        end
        if (r_rd_tap[0]) begin
            term = -term;
        end
        sq  = r_s * r_s;
        mag = r_zero ? '0 : sq[MAG_W-1:0];
        nms = (r_slot[0] > r_slot[1] && r_slot[0] > r_slot[2])
           || (r_slot[0] > r_slot[3] && r_slot[0] > r_slot[4]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[{i_cmd.wr_row, i_cmd.wr_col}] <= i_pixel;
        end
        if (i_cmd.rd_en) begin
            r_rd     <= r_mem[rd_addr];
            r_rd_tap <= i_cmd.tap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_job) begin
            r_up   <= (i_cmd.job_row == '0) ? RING_W'(1)
                                            : i_cmd.job_row[RING_W-1:0] - RING_W'(1);
            r_mid  <= i_cmd.job_row[RING_W-1:0];
            r_dn   <= ({1'b0, i_cmd.job_row} + HGT_W'(1) == i_height)
                    ? i_cmd.job_row[RING_W-1:0] - RING_W'(1)
                    : i_cmd.job_row[RING_W-1:0] + RING_W'(1);
            r_cp   <= i_cmd.job_col + COL_W'(1);
            r_cm   <= i_cmd.job_col - COL_W'(1);
            r_zero <= (i_cmd.job_col == '0) || ({1'b0, i_cmd.job_col} + WID_W'(1) >= i_width);
            r_s    <= '0;
        end else if (r_rd_v) begin
            r_s <= r_s + term;
        end
        if (i_cmd.sq_en) begin
            r_slot[i_cmd.slot] <= mag;
            r_mq               <= mag;
        end
        if (i_cmd.cmp1) begin
            r_lhs <= r_slot[0] * i_npix;
            r_rhs <= i_scale * r_sum;
        end
        if (i_cmd.out_load) begin
            r_oedge <= r_hit ? EDGE_ON : '0;
            r_olast <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_sum  <= '0;
            r_hit  <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
            if (i_cmd.sum_clr) begin
                r_sum <= '0;
            end else if (i_cmd.sum_add) begin
                r_sum <= r_sum + {{(SUM_W-MAG_W){1'b0}}, r_mq};
            end
            if (i_cmd.hit_clr) begin
                r_hit <= 1'b0;
            end else if (i_cmd.cmp2) begin
                r_hit <= ({{(RHS_W-LHS_W){1'b0}}, r_lhs} > r_rhs) && nms;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_stat.out_free = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_edge  = r_oedge;
    assign o_last  = r_olast;
endmodule

>>> hdl/vent_ctrl.sv
// Controller: pass and position tracking, magnitude job sequencing and
// result release. Uses vent_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vent_ctrl import vent_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [REQ_W-1:0] i_req,
    input  logic [WID_W-1:0] i_width,
    input  logic [HGT_W-1:0] i_height,
    input  logic [N_W-1:0]   i_npix,
    input  logic             i_geom_wr,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);
    t_state           r_state, n_state;
    logic             r_pass;
    logic [COL_W-1:0] r_col, r_ec, r_bc;
    logic [ROW_W-1:0] r_row, r_er, r_br;
    logic [N_W-1:0]   r_t, r_e;
    logic             r_all_in, r_mode, r_need_b, r_last;
    logic [2:0]       r_idx, r_tap;

    logic acc, col_last, row_last, p0_pix, p1_only, p1_pix, store;
    logic need_a, need_b, lag_ok, emit_go, border, ec_last, done_out;

    always_comb begin
        acc      = i_valid && (r_state == S_IDLE);
        col_last = {1'b0, r_col} == i_width - WID_W'(1);
        row_last = {1'b0, r_row} == i_height - HGT_W'(1);
        p0_pix   = !r_pass && (i_req == REQ_ACC);
        p1_only  = r_pass && r_all_in && (i_req == REQ_EMIT || i_req == REQ_FLUSH);
        p1_pix   = r_pass && !r_all_in && (i_req == REQ_EMIT);
        store    = acc && (p0_pix || p1_pix);
        need_a   = (r_col >= COL_W'(2)) && (r_row != '0);
        need_b   = (r_col >= COL_W'(2)) && row_last;
        lag_ok   = ({1'b0, r_e} + {{(N_W-WID_W){1'b0}}, i_width, 1'b0} + (N_W+1)'(2))
                <= {1'b0, r_t};
        emit_go  = acc && (p1_only || (p1_pix && lag_ok));
        border   = (r_er == '0) || ({1'b0, r_er} == i_height - HGT_W'(1))
                || (r_ec == '0) || ({1'b0, r_ec} == i_width - WID_W'(1));
        ec_last  = {1'b0, r_ec} == i_width - WID_W'(1);
        done_out = (r_state == S_OUT) && i_stat.out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && p0_pix && (need_a || need_b)) begin
                    n_state = S_MLD;
                end else if (emit_go) begin
                    n_state = border ? S_OUT : S_MLD;
                end
            end
            S_MLD:  n_state = S_MRD;
            S_MRD:  n_state = (r_tap == TAP_LAST) ? S_MACC : S_MRD;
            S_MACC: n_state = S_MSQ;
            S_MSQ: begin
                if (!r_mode) begin
                    n_state = S_MSUM;
                end else begin
                    n_state = (r_idx == SLOT_LAST) ? S_CMP1 : S_MLD;
                end
            end
            S_MSUM: n_state = (r_idx == 3'd0 && r_need_b) ? S_MLD : S_IDLE;
            S_CMP1: n_state = S_CMP2;
            S_CMP2: n_state = S_OUT;
            S_OUT:  n_state = i_stat.out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.wr_row  = r_row[RING_W-1:0];
        o_cmd.wr_col  = r_col;
        o_cmd.tap     = r_tap;
        o_cmd.slot    = r_idx;
        o_cmd.out_last = r_last;
        o_cmd.sum_clr = i_geom_wr || (done_out && r_last);
        if (!r_mode) begin
            o_cmd.job_row = (r_idx == 3'd0) ? r_br - ROW_W'(1) : r_br;
            o_cmd.job_col = r_bc;
        end else begin
            case (r_idx)
                3'd1:    begin o_cmd.job_row = r_br; o_cmd.job_col = r_bc - COL_W'(1); end
                3'd2:    begin o_cmd.job_row = r_br; o_cmd.job_col = r_bc + COL_W'(1); end
                3'd3:    begin o_cmd.job_row = r_br - ROW_W'(1); o_cmd.job_col = r_bc; end
                3'd4:    begin o_cmd.job_row = r_br + ROW_W'(1); o_cmd.job_col = r_bc; end
                default: begin o_cmd.job_row = r_br; o_cmd.job_col = r_bc; end
            endcase
        end
        case (r_state)
            S_IDLE: begin
                o_cmd.wr_en   = store;
                o_cmd.hit_clr = emit_go;
            end
            S_MLD:   o_cmd.ld_job   = 1'b1;
            S_MRD:   o_cmd.rd_en    = 1'b1;
            S_MSQ:   o_cmd.sq_en    = 1'b1;
            S_MSUM:  o_cmd.sum_add  = 1'b1;
            S_CMP1:  o_cmd.cmp1     = 1'b1;
            S_CMP2:  o_cmd.cmp2     = 1'b1;
            S_OUT:   o_cmd.out_load = i_stat.out_free;
            default: o_cmd.ld_job   = 1'b0;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pass   <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_t      <= '0;
            r_e      <= '0;
            r_er     <= '0;
            r_ec     <= '0;
            r_all_in <= 1'b0;
            r_mode   <= 1'b0;
            r_idx    <= '0;
            r_tap    <= '0;
            r_need_b <= 1'b0;
            r_last   <= 1'b0;
            r_br     <= '0;
            r_bc     <= '0;
        end else if (i_geom_wr) begin
            r_state  <= S_IDLE;
            r_pass   <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_t      <= '0;
            r_e      <= '0;
            r_er     <= '0;
            r_ec     <= '0;
            r_all_in <= 1'b0;
        end else begin
            r_state <= n_state;
            if (store) begin
                if (col_last) begin
                    r_col <= '0;
                    if (row_last) begin
                        r_row <= '0;
                        if (!r_pass) begin
                            r_pass   <= 1'b1;
                            r_t      <= '0;
                            r_e      <= '0;
                            r_er     <= '0;
                            r_ec     <= '0;
                            r_all_in <= 1'b0;
                        end else begin
                            r_all_in <= 1'b1;
                        end
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (acc && p1_pix) begin
                r_t <= r_t + N_W'(1);
            end
            if (acc && p0_pix) begin
                r_mode   <= 1'b0;
                r_br     <= r_row;
                r_bc     <= r_col - COL_W'(1);
                r_need_b <= need_b;
                r_idx    <= need_a ? 3'd0 : 3'd1;
            end
            if (emit_go) begin
                r_mode <= 1'b1;
                r_br   <= r_er;
                r_bc   <= r_ec;
                r_idx  <= 3'd0;
                r_last <= ({1'b0, r_e} + (N_W+1)'(1)) == {1'b0, i_npix};
            end
            case (r_state)
                S_MLD:  r_tap <= '0;
                S_MRD:  r_tap <= r_tap + 3'd1;
                S_MSQ: begin
                    if (r_mode && r_idx != SLOT_LAST) begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
                S_MSUM: r_idx <= 3'd1;
                default: r_tap <= r_tap;
            endcase
            if (done_out) begin
                if (r_last) begin
                    r_pass   <= 1'b0;
                    r_col    <= '0;
                    r_row    <= '0;
                    r_t      <= '0;
                    r_e      <= '0;
                    r_er     <= '0;
                    r_ec     <= '0;
                    r_all_in <= 1'b0;
                end else begin
                    r_e <= r_e + N_W'(1);
                    if (ec_last) begin
                        r_ec <= '0;
                        r_er <= r_er + ROW_W'(1);
                    end else begin
                        r_ec <= r_ec + COL_W'(1);
                    end
                end
            end
        end
    end

    `ASSERT_CLK(a_load_free, i_clk, i_rst_n, o_cmd.out_load |-> i_stat.out_free, "result overwritten")
    `ASSERT_CLK(a_last_clears, i_clk, i_rst_n, (done_out && r_last) |=> !r_pass, "frame not closed")
    `ASSERT_CLK(a_emit_lag, i_clk, i_rst_n, r_pass |-> (r_e <= r_t), "result ahead of input")
endmodule
